@@ rtl/gbpt_pkg.sv @@
// Shared types and constants for the GPIO button and PWM timer unit.
package gbpt_pkg;

  localparam int unsigned PortW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDirB     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDirC     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDirD     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTimerEn  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCompare  = 3'd4;

  // Port select codes
  localparam logic [1:0] SelPortB = 2'd0;
  localparam logic [1:0] SelPortC = 2'd1;
  localparam logic [1:0] SelPortD = 2'd2;

  // Item kinds carried on tuser
  localparam logic FuncTick  = 1'b0;
  localparam logic FuncWrite = 1'b1;

  localparam logic [CountW-1:0] CountTop = 16'hFFFF;
  localparam logic [CountW-1:0] CountBot = 16'h0000;

  // Compare output sits on port B bit 1
  localparam int unsigned PwmBit = 1;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              down;
  } timer_state_t;

endpackage

@@ rtl/gbpt_scan.sv @@
// Button scan for one 8-bit port: works out new pin levels and held mask.
module gbpt_scan (
  input  logic [gbpt_pkg::PortW-1:0] keys,
  input  logic [gbpt_pkg::PortW-1:0] dir,
  input  logic [gbpt_pkg::PortW-1:0] out_val,
  input  logic [gbpt_pkg::PortW-1:0] pins,
  input  logic [gbpt_pkg::PortW-1:0] held,
  output logic [gbpt_pkg::PortW-1:0] pins_next,
  output logic [gbpt_pkg::PortW-1:0] held_next
);

  logic [gbpt_pkg::PortW-1:0] press;
  logic [gbpt_pkg::PortW-1:0] newly;
  logic [gbpt_pkg::PortW-1:0] gone;

  always_comb begin
    press     = keys & ~dir;
    newly     = press & ~held;
    gone      = held & ~press;
    // new press shows the inverted output bit, release restores it
    pins_next = (pins & ~(newly | gone)) | (newly & ~out_val) | (gone & out_val);
    held_next = press;
  end

endmodule

@@ rtl/gbpt_timer.sv @@
// Phase-correct 16-bit up/down counter step and compare drive of port B bit 1.
module gbpt_timer (
  input  logic                        step,
  input  gbpt_pkg::timer_state_t      cur,
  input  logic [gbpt_pkg::CountW-1:0] compare_value,
  input  logic                        pwm_in,
  output gbpt_pkg::timer_state_t      nxt,
  output logic                        pwm_out
);

  always_comb begin
    nxt     = cur;
    pwm_out = pwm_in;
    if (step) begin
      if (cur.down) begin
        nxt.count = cur.count - gbpt_pkg::CountW'(1);
        if (nxt.count == gbpt_pkg::CountBot) begin
          nxt.down = 1'b0;
        end
      end else begin
        nxt.count = cur.count + gbpt_pkg::CountW'(1);
        if (nxt.count == gbpt_pkg::CountTop) begin
          nxt.down = 1'b1;
        end
      end
      if (nxt.count == compare_value) begin
        pwm_out = ~nxt.down;
      end
    end
  end

endmodule

@@ rtl/gpio_button_and_pwm_timer_unit.sv @@
// Top level of the GPIO button and PWM timer unit.
//
// Input stream (s_*): one transaction is a tick (tuser 0) carrying the button
// states of ports B, C and D, or a port write (tuser 1) carrying a port select
// and an output byte. Every input transaction yields exactly one output
// transaction (m_*) with all pin levels, output bytes and the counter state
// after that item.
// The state update and the result are registered at the edge that accepts
// the item. Throughput is one item per clock while the receiver does not
// stall; the state registers and the result register form a single stage,
// so the only limit is the result register itself.
// When the receiver stalls, the result stays in the output register and one
// more item is not taken until it leaves (s_tready = !m_tvalid | m_tready).
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// should be made while no item is in flight; unknown indexes are ignored.
// Synchronous reset clears all port, pin, held, counter and configuration
// state and empties the output register.
module gpio_button_and_pwm_timer_unit (
  input  logic                          clk,
  input  logic                          rst,
  // tdata: port_select[1:0], write_value[9:2], keys_b[17:10], keys_c[25:18],
  //        keys_d[33:26], zero fill
  input  logic [gbpt_pkg::InDataW-1:0]  s_tdata,
  // tuser: func[0]
  input  logic                          s_tuser,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata: pins_b[7:0], pins_c[15:8], pins_d[23:16], out_b[31:24],
  //        out_c[39:32], out_d[47:40], timer_count[63:48], counting_down[64],
  //        zero fill
  output logic [gbpt_pkg::OutDataW-1:0] m_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          cfg_we,
  input  logic [gbpt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gbpt_pkg::CfgDataW-1:0] cfg_data
);

  localparam int unsigned W = gbpt_pkg::PortW;

  // configuration
  logic [W-1:0]                dir_b, dir_c, dir_d;
  logic                        timer_enable;
  logic [gbpt_pkg::CountW-1:0] compare_value;

  // state
  logic [W-1:0] out_reg_b, out_reg_c, out_reg_d;
  logic [W-1:0] pin_reg_b, pin_reg_c, pin_reg_d;
  logic [W-1:0] held_b, held_c, held_d;
  gbpt_pkg::timer_state_t tmr;

  logic [W-1:0] out_reg_b_next, out_reg_c_next, out_reg_d_next;
  logic [W-1:0] pin_reg_b_next, pin_reg_c_next, pin_reg_d_next;
  logic [W-1:0] held_b_next, held_c_next, held_d_next;
  gbpt_pkg::timer_state_t tmr_next;

  logic [W-1:0] scan_pins_b, scan_pins_c, scan_pins_d;
  logic [W-1:0] scan_held_b, scan_held_c, scan_held_d;
  logic         pwm_next;

  logic [1:0]   port_select;
  logic [W-1:0] write_value, keys_b, keys_c, keys_d;
  logic         accept;
  logic         tick;

  assign port_select = s_tdata[1:0];
  assign write_value = s_tdata[9:2];
  assign keys_b      = s_tdata[17:10];
  assign keys_c      = s_tdata[25:18];
  assign keys_d      = s_tdata[33:26];

  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;
  assign tick     = (s_tuser == gbpt_pkg::FuncTick);

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_b         <= '0;
      dir_c         <= '0;
      dir_d         <= '0;
      timer_enable  <= 1'b0;
      compare_value <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbpt_pkg::CfgDirB:    dir_b         <= cfg_data[W-1:0];
        gbpt_pkg::CfgDirC:    dir_c         <= cfg_data[W-1:0];
        gbpt_pkg::CfgDirD:    dir_d         <= cfg_data[W-1:0];
        gbpt_pkg::CfgTimerEn: timer_enable  <= cfg_data[0];
        gbpt_pkg::CfgCompare: compare_value <= cfg_data[gbpt_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  gbpt_scan u_scan_b (
    .keys(keys_b), .dir(dir_b), .out_val(out_reg_b), .pins(pin_reg_b),
    .held(held_b), .pins_next(scan_pins_b), .held_next(scan_held_b)
  );

  gbpt_scan u_scan_c (
    .keys(keys_c), .dir(dir_c), .out_val(out_reg_c), .pins(pin_reg_c),
    .held(held_c), .pins_next(scan_pins_c), .held_next(scan_held_c)
  );

  gbpt_scan u_scan_d (
    .keys(keys_d), .dir(dir_d), .out_val(out_reg_d), .pins(pin_reg_d),
    .held(held_d), .pins_next(scan_pins_d), .held_next(scan_held_d)
  );

  gbpt_timer u_timer (
    .step(tick & timer_enable),
    .cur(tmr),
    .compare_value(compare_value),
    .pwm_in(out_reg_b[gbpt_pkg::PwmBit]),
    .nxt(tmr_next),
    .pwm_out(pwm_next)
  );

  always_comb begin
    out_reg_b_next = out_reg_b;
    out_reg_c_next = out_reg_c;
    out_reg_d_next = out_reg_d;
    pin_reg_b_next = pin_reg_b;
    pin_reg_c_next = pin_reg_c;
    pin_reg_d_next = pin_reg_d;
    held_b_next    = held_b;
    held_c_next    = held_c;
    held_d_next    = held_d;
    if (tick) begin
      pin_reg_b_next = scan_pins_b;
      pin_reg_c_next = scan_pins_c;
      pin_reg_d_next = scan_pins_d;
      held_b_next    = scan_held_b;
      held_c_next    = scan_held_c;
      held_d_next    = scan_held_d;
      // timer only touches the output byte, after the pins were scanned
      out_reg_b_next[gbpt_pkg::PwmBit] = pwm_next;
    end else begin
      unique case (port_select)
        gbpt_pkg::SelPortB: begin
          out_reg_b_next = write_value;
          pin_reg_b_next = write_value & ~dir_b;
        end
        gbpt_pkg::SelPortC: begin
          out_reg_c_next = write_value;
          pin_reg_c_next = write_value & ~dir_c;
        end
        gbpt_pkg::SelPortD: begin
          out_reg_d_next = write_value;
          pin_reg_d_next = write_value & ~dir_d;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg_b <= '0;
      out_reg_c <= '0;
      out_reg_d <= '0;
      pin_reg_b <= '0;
      pin_reg_c <= '0;
      pin_reg_d <= '0;
      held_b    <= '0;
      held_c    <= '0;
      held_d    <= '0;
      tmr       <= '0;
    end else if (accept) begin
      out_reg_b <= out_reg_b_next;
      out_reg_c <= out_reg_c_next;
      out_reg_d <= out_reg_d_next;
      pin_reg_b <= pin_reg_b_next;
      pin_reg_c <= pin_reg_c_next;
      pin_reg_d <= pin_reg_d_next;
      held_b    <= held_b_next;
      held_c    <= held_c_next;
      held_d    <= held_d_next;
      tmr       <= (tick) ? tmr_next : tmr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0, (tick ? tmr_next.down : tmr.down),
                  (tick ? tmr_next.count : tmr.count),
                  out_reg_d_next, out_reg_c_next, out_reg_b_next,
                  pin_reg_d_next, pin_reg_c_next, pin_reg_b_next};
    end
  end

endmodule

@@ rtl/gbpt_checker.sv @@
// Port-level checks for the GPIO button and PWM timer unit, bound to the top level.
module gbpt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [gbpt_pkg::OutDataW-1:0] m_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output transaction changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item produced no result");

  // counter never sits at the bottom while falling or at the top while rising
  a_turn_points: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[64] && m_tdata[63:48] == gbpt_pkg::CountBot) &&
                 !(!m_tdata[64] && m_tdata[63:48] == gbpt_pkg::CountTop))
    else $error("counter direction inconsistent with count");

endmodule

bind gpio_button_and_pwm_timer_unit gbpt_checker u_gbpt_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tdata(m_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready)
);
